@@ design/ftsq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftsq_pkg
// Shared constants and types of the floppy transfer sequencer.
// ----------------------------------------------------------------------------
package ftsq_pkg;

    // Field widths
    localparam int BLOCK_BITS_DEF = 13;
    localparam int TOTAL_W        = 13;
    localparam int SPT_W          = 6;
    localparam int GAP_W          = 8;
    localparam int RETRY_W        = 4;
    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int OP_W           = 2;
    localparam int KIND_W         = 3;
    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 8;
    localparam int OFF_W          = 22;
    localparam int LEN_W          = 16;
    localparam int CHUNK_W        = 7;
    localparam int SECTOR_SHIFT   = 9;
    localparam int EMIT_IDX_W     = 4;
    localparam int WIDE_W         = 32;

    // Number of results in each emitted sequence
    localparam int SEEK_LEN = 3;
    localparam int IO_LEN   = 10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY = 2'd3;

    // Register reset values
    localparam logic [SPT_W-1:0]   RST_SPT   = 6'd18;
    localparam logic [TOTAL_W-1:0] RST_TOTAL = 13'd2880;
    localparam logic [GAP_W-1:0]   RST_GAP   = 8'd23;
    localparam logic [RETRY_W-1:0] RST_RETRY = 4'd8;

    // Input opcodes
    localparam logic [OP_W-1:0] OP_START     = 2'd0;
    localparam logic [OP_W-1:0] OP_SEEK_DONE = 2'd1;
    localparam logic [OP_W-1:0] OP_XFER_DONE = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CMD     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DMA     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DONE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IOERR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INVALID = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BUSY    = 3'd5;

    // Request phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEEK = 2'd1;
    localparam logic [1:0] PH_XFER = 2'd2;

    // Controller command bytes
    localparam logic [BYTE_W-1:0] CMD_SEEK  = 8'h0F;
    localparam logic [BYTE_W-1:0] CMD_READ  = 8'hC6;
    localparam logic [BYTE_W-1:0] CMD_WRITE = 8'hC5;
    localparam logic [BYTE_W-1:0] SIZE_CODE = 8'h02;
    localparam logic [BYTE_W-1:0] DTL_BYTE  = 8'hFF;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        EM_SEEK,
        EM_IO,
        EM_END
    } t_emit;

endpackage

`default_nettype wire

@@ design/ftsq_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftsq_divider
// Restoring divider, one quotient bit per cycle, for block to cylinder split.
// ----------------------------------------------------------------------------
module ftsq_divider import ftsq_pkg::*; #(
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [BLOCK_BITS-1:0] i_dividend,
    input  wire logic [CHUNK_W-1:0]    i_divisor,
    output logic                       o_done,
    output logic [BLOCK_BITS-1:0]      o_quotient,
    output logic [CHUNK_W-1:0]         o_remainder
);

    localparam int CNT_W = $clog2(BLOCK_BITS + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;
    logic [BLOCK_BITS-1:0] r_quo;
    logic [CHUNK_W-1:0]    r_rem;
    logic [CHUNK_W:0]      trial;
    logic [CHUNK_W:0]      diff;
    logic                  ge;

    assign trial = {r_rem, r_quo[BLOCK_BITS-1]};
    assign ge    = trial >= {1'b0, i_divisor};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(BLOCK_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // The dividend shifts out of the quotient register as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[BLOCK_BITS-2:0], ge};
            r_rem <= ge ? diff[CHUNK_W-1:0] : trial[CHUNK_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

@@ design/floppy_transfer_sequencer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// floppy_transfer_sequencer_unit
// Turns block requests into seek, DMA setup and read/write command transfers.
// ----------------------------------------------------------------------------
// The unit takes one input transfer at a time and stalls its input until the
// last result of that transfer has been loaded into the output register. An
// event that leads to a seek or a read/write command splits the current block
// into track, head and sector with a serial divider that produces one quotient
// bit per cycle, then emits its results (three for a seek, ten for a read/write).
// Events that end or refuse a request give a single result; ignored events give
// none. Results wait in an output register while the output is stalled.
module floppy_transfer_sequencer_unit import ftsq_pkg::*; #(
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [OP_W-1:0]       i_opcode,
    input  wire logic                  i_drive_unit,
    input  wire logic [BLOCK_BITS-1:0] i_start_block,
    input  wire logic [BLOCK_BITS-1:0] i_sector_count,
    input  wire logic                  i_is_write,
    input  wire logic [STATUS_W-1:0]   i_status_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [KIND_W-1:0]          o_kind,
    output logic [BYTE_W-1:0]          o_byte_value,
    output logic [OFF_W-1:0]           o_dma_offset,
    output logic [LEN_W-1:0]           o_dma_length,
    output logic                       o_dma_is_write,
    output logic                       o_last
);

    localparam int CMP_W = (BLOCK_BITS > TOTAL_W) ? BLOCK_BITS : TOTAL_W;

    // Configuration
    logic [SPT_W-1:0]   r_spt;
    logic [TOTAL_W-1:0] r_total;
    logic [GAP_W-1:0]   r_gap;
    logic [RETRY_W-1:0] r_retry_limit;

    // Request state
    t_state                r_state;
    logic [1:0]            r_phase;
    logic                  r_unit;
    logic                  r_wdir;
    logic [BLOCK_BITS-1:0] r_block;
    logic [BLOCK_BITS-1:0] r_remain;
    logic [BLOCK_BITS-1:0] r_done;
    logic [CHUNK_W-1:0]    r_chunk;
    logic [RETRY_W-1:0]    r_retry;

    // Sequencer
    logic                  r_goal_io;
    t_emit                 r_mode;
    logic [KIND_W-1:0]     r_end_kind;
    logic [EMIT_IDX_W-1:0] r_emit_idx;
    logic                  r_div_start;
    logic                  r_head;
    logic [SPT_W-1:0]      r_sector;

    // Output register
    logic                  r_out_valid;
    logic [KIND_W-1:0]     r_kind;
    logic [BYTE_W-1:0]     r_byte;
    logic [OFF_W-1:0]      r_off;
    logic [LEN_W-1:0]      r_len;
    logic                  r_dw;
    logic                  r_last;

    // Divider
    logic                  div_done;
    logic [BLOCK_BITS-1:0] div_quo;
    logic [CHUNK_W-1:0]    div_rem;
    logic [CHUNK_W-1:0]    cyl;

    logic                  in_fire;
    logic                  fail;
    logic [BLOCK_BITS-1:0] chunk_ext;
    logic [BLOCK_BITS:0]   next_block;
    logic [BLOCK_BITS-1:0] remain_after;
    logic                  block_bad;

    logic                  head_calc;
    logic [CHUNK_W-1:0]    spt_ext;
    logic [CHUNK_W-1:0]    sector_calc;
    logic [CHUNK_W-1:0]    span;
    logic [CHUNK_W-1:0]    span_sel;
    logic [CHUNK_W-1:0]    chunk_calc;

    logic                  emit_fire;
    logic                  e_last;
    logic [KIND_W-1:0]     e_kind;
    logic [BYTE_W-1:0]     e_byte;
    logic [OFF_W-1:0]      e_off;
    logic [LEN_W-1:0]      e_len;
    logic                  e_dw;
    logic [BYTE_W-1:0]     hd_unit;
    logic [WIDE_W-1:0]     off_wide;
    logic [WIDE_W-1:0]     len_wide;

    ftsq_divider #(
        .BLOCK_BITS (BLOCK_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_block),
        .i_divisor   (cyl),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt         <= RST_SPT;
            r_total       <= RST_TOTAL;
            r_gap         <= RST_GAP;
            r_retry_limit <= RST_RETRY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPT:   r_spt         <= i_cfg_data[SPT_W-1:0];
                CFG_TOTAL: r_total       <= i_cfg_data[TOTAL_W-1:0];
                CFG_GAP:   r_gap         <= i_cfg_data[GAP_W-1:0];
                CFG_RETRY: r_retry_limit <= i_cfg_data[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_fire    = i_in_valid && (r_state == ST_IDLE);
    assign fail       = |i_status_byte[STATUS_W-1:STATUS_W-2];

    assign cyl          = {r_spt, 1'b0};
    assign chunk_ext    = BLOCK_BITS'(r_chunk);
    assign next_block   = {1'b0, r_block} + {1'b0, chunk_ext};
    assign remain_after = r_remain - chunk_ext;
    assign block_bad    = (r_spt == '0) || (CMP_W'(r_block) >= CMP_W'(r_total));

    // The remainder is below two tracks, so the head is a single compare.
    assign spt_ext     = CHUNK_W'(r_spt);
    assign head_calc   = div_rem >= spt_ext;
    assign sector_calc = div_rem - (head_calc ? spt_ext : '0) + CHUNK_W'(1);
    assign span        = cyl - div_rem;
    assign span_sel    = (r_retry == '0) ? span : CHUNK_W'(1);
    assign chunk_calc  = (BLOCK_BITS'(span_sel) > r_remain) ? r_remain[CHUNK_W-1:0] : span_sel;

    assign emit_fire = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_unit      <= 1'b0;
            r_wdir      <= 1'b0;
            r_block     <= '0;
            r_remain    <= '0;
            r_done      <= '0;
            r_chunk     <= '0;
            r_retry     <= '0;
            r_goal_io   <= 1'b0;
            r_mode      <= EM_END;
            r_end_kind  <= KIND_DONE;
            r_emit_idx  <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_emit_idx <= '0;
                    if (in_fire) begin
                        case (i_opcode)
                            OP_START: begin
                                if (r_phase != PH_IDLE) begin
                                    r_mode     <= EM_END;
                                    r_end_kind <= KIND_BUSY;
                                    r_state    <= ST_EMIT;
                                end else begin
                                    r_unit   <= i_drive_unit;
                                    r_block  <= i_start_block;
                                    r_remain <= i_sector_count;
                                    r_wdir   <= i_is_write;
                                    r_done   <= '0;
                                    r_chunk  <= '0;
                                    r_retry  <= '0;
                                    if (i_sector_count == '0) begin
                                        r_mode     <= EM_END;
                                        r_end_kind <= KIND_DONE;
                                        r_state    <= ST_EMIT;
                                    end else begin
                                        r_goal_io <= 1'b0;
                                        r_state   <= ST_PREP;
                                    end
                                end
                            end
                            OP_SEEK_DONE: begin
                                if (r_phase == PH_SEEK) begin
                                    if (fail) begin
                                        r_phase    <= PH_IDLE;
                                        r_mode     <= EM_END;
                                        r_end_kind <= KIND_IOERR;
                                        r_state    <= ST_EMIT;
                                    end else begin
                                        r_goal_io <= 1'b1;
                                        r_state   <= ST_PREP;
                                    end
                                end
                            end
                            OP_XFER_DONE: begin
                                if (r_phase == PH_XFER) begin
                                    if (fail) begin
                                        if (r_retry >= r_retry_limit) begin
                                            r_phase    <= PH_IDLE;
                                            r_mode     <= EM_END;
                                            r_end_kind <= KIND_IOERR;
                                            r_state    <= ST_EMIT;
                                        end else begin
                                            r_retry   <= r_retry + RETRY_W'(1);
                                            r_goal_io <= 1'b0;
                                            r_state   <= ST_PREP;
                                        end
                                    end else begin
                                        r_remain <= remain_after;
                                        r_done   <= r_done + chunk_ext;
                                        r_block  <= next_block[BLOCK_BITS-1:0];
                                        r_retry  <= '0;
                                        if (remain_after == '0) begin
                                            r_phase    <= PH_IDLE;
                                            r_mode     <= EM_END;
                                            r_end_kind <= KIND_DONE;
                                            r_state    <= ST_EMIT;
                                        end else if (next_block[BLOCK_BITS]) begin
                                            r_phase    <= PH_IDLE;
                                            r_mode     <= EM_END;
                                            r_end_kind <= KIND_INVALID;
                                            r_state    <= ST_EMIT;
                                        end else begin
                                            r_goal_io <= 1'b1;
                                            r_state   <= ST_PREP;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PREP: begin
                    // The range check runs before every seek and every transfer.
                    if (block_bad) begin
                        r_phase    <= PH_IDLE;
                        r_mode     <= EM_END;
                        r_end_kind <= KIND_INVALID;
                        r_state    <= ST_EMIT;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_head   <= head_calc;
                    r_sector <= sector_calc[SPT_W-1:0];
                    if (r_goal_io) begin
                        r_chunk <= chunk_calc;
                        r_mode  <= EM_IO;
                        r_phase <= PH_XFER;
                    end else begin
                        r_mode  <= EM_SEEK;
                        r_phase <= PH_SEEK;
                    end
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        r_emit_idx <= r_emit_idx + EMIT_IDX_W'(1);
                        if (e_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // r_head and r_sector are payload only, loaded in the finishing cycle.
    // They are declared with the sequencer state but carry no reset.

    assign hd_unit  = {5'b0, r_head, 1'b0, r_unit};
    assign off_wide = WIDE_W'({r_done, {SECTOR_SHIFT{1'b0}}});
    assign len_wide = WIDE_W'({r_chunk, {SECTOR_SHIFT{1'b0}}});

    always_comb begin
        e_kind = KIND_CMD;
        e_byte = '0;
        e_off  = '0;
        e_len  = '0;
        e_dw   = 1'b0;
        e_last = 1'b0;
        case (r_mode)
            EM_SEEK: begin
                e_last = (r_emit_idx == EMIT_IDX_W'(SEEK_LEN - 1));
                case (r_emit_idx)
                    4'd0:    e_byte = CMD_SEEK;
                    4'd1:    e_byte = hd_unit;
                    default: e_byte = div_quo[BYTE_W-1:0];
                endcase
            end
            EM_IO: begin
                e_last = (r_emit_idx == EMIT_IDX_W'(IO_LEN - 1));
                case (r_emit_idx)
                    4'd0: begin
                        e_kind = KIND_DMA;
                        e_off  = off_wide[OFF_W-1:0];
                        e_len  = len_wide[LEN_W-1:0];
                        e_dw   = r_wdir;
                    end
                    4'd1:    e_byte = r_wdir ? CMD_WRITE : CMD_READ;
                    4'd2:    e_byte = hd_unit;
                    4'd3:    e_byte = div_quo[BYTE_W-1:0];
                    4'd4:    e_byte = BYTE_W'(r_head);
                    4'd5:    e_byte = BYTE_W'(r_sector);
                    4'd6:    e_byte = SIZE_CODE;
                    4'd7:    e_byte = BYTE_W'(r_spt);
                    4'd8:    e_byte = r_gap;
                    default: e_byte = DTL_BYTE;
                endcase
            end
            default: begin
                e_kind = r_end_kind;
                e_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_kind <= e_kind;
            r_byte <= e_byte;
            r_off  <= e_off;
            r_len  <= e_len;
            r_dw   <= e_dw;
            r_last <= e_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_byte_value   = r_byte;
    assign o_dma_offset   = r_off;
    assign o_dma_length   = r_len;
    assign o_dma_is_write = r_dw;
    assign o_last         = r_last;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    // Emission never runs past the end of a command sequence.
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |->
            ((r_mode == EM_SEEK && r_emit_idx < EMIT_IDX_W'(SEEK_LEN)) ||
             (r_mode == EM_IO && r_emit_idx < EMIT_IDX_W'(IO_LEN)) ||
             (r_mode == EM_END && r_emit_idx == '0)))
        else $error("emit index beyond sequence length");

    // Loading the final result of an event frees the input side.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && e_last) |=> (r_state == ST_IDLE && r_out_valid && r_last))
        else $error("sequencer did not return to idle after the final result");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the floppy transfer sequencer. A short list of
// directed transfers covers the corner cases. Random request sequences then
// run under several register settings and idle and stall patterns. Each result
// transfer is checked against a behavioral model of the sequencer or a listed kind.
// ----------------------------------------------------------------------------
module tb;
    import ftsq_pkg::*;

    localparam int BB           = BLOCK_BITS_DEF;
    localparam int BLOCK_MASK   = (1 << BB) - 1;
    localparam int DRAIN_CYCLES = 48;
    localparam int LIMIT_NS     = 5_000_000;
    localparam int MAX_REPORTS  = 40;

    // Opcode that the sequencer never acts on.
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    // Marks a directed row whose results come from the model, not from the list.
    localparam logic [KIND_W-1:0] KIND_PREDICTED = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] byte_value;
        logic [OFF_W-1:0]  dma_offset;
        logic [LEN_W-1:0]  dma_length;
        logic              dma_is_write;
        logic              last;
    } fdc_result_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] cfg_index;
        logic [CFG_W-1:0]     cfg_value;
        logic [OP_W-1:0]      op;
        logic                 unit;
        logic [BB-1:0]        blk;
        logic [BB-1:0]        cnt;
        logic                 wr;
        logic [STATUS_W-1:0]  st;
        logic [KIND_W-1:0]    kind;
    } directed_row_t;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic [OP_W-1:0]      i_opcode       = '0;
    logic                 i_drive_unit   = 1'b0;
    logic [BB-1:0]        i_start_block  = '0;
    logic [BB-1:0]        i_sector_count = '0;
    logic                 i_is_write     = 1'b0;
    logic [STATUS_W-1:0]  i_status_byte  = '0;
    logic                 i_out_stall    = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [KIND_W-1:0]    o_kind;
    logic [BYTE_W-1:0]    o_byte_value;
    logic [OFF_W-1:0]     o_dma_offset;
    logic [LEN_W-1:0]     o_dma_length;
    logic                 o_dma_is_write;
    logic                 o_last;

    // Model registers and request state.
    logic [SPT_W-1:0]   spt_q;
    logic [TOTAL_W-1:0] total_q;
    logic [GAP_W-1:0]   gap_q;
    logic [RETRY_W-1:0] retry_lim_q;
    logic [1:0]         phase_q;
    logic               unit_q;
    logic               dir_q;
    logic [BB-1:0]      blk_q;
    logic [BB-1:0]      left_q;
    logic [BB-1:0]      done_q;
    logic [CHUNK_W-1:0] chunk_q;
    logic [RETRY_W-1:0] retries_q;

    fdc_result_t   caused_results[$];
    fdc_result_t   awaited_results[$];
    directed_row_t directed_rows[$];
    fdc_result_t   seen;
    fdc_result_t   want;
    int            error_count   = 0;
    int            send_idle_pct = 0;
    int            out_stall_pct = 0;

    floppy_transfer_sequencer_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_drive_unit   (i_drive_unit),
        .i_start_block  (i_start_block),
        .i_sector_count (i_sector_count),
        .i_is_write     (i_is_write),
        .i_status_byte  (i_status_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_byte_value   (o_byte_value),
        .o_dma_offset   (o_dma_offset),
        .o_dma_length   (o_dma_length),
        .o_dma_is_write (o_dma_is_write),
        .o_last         (o_last)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------
    function automatic void reset_model();
        spt_q       = RST_SPT;
        total_q     = RST_TOTAL;
        gap_q       = RST_GAP;
        retry_lim_q = RST_RETRY;
        phase_q     = PH_IDLE;
        unit_q      = 1'b0;
        dir_q       = 1'b0;
        blk_q       = '0;
        left_q      = '0;
        done_q      = '0;
        chunk_q     = '0;
        retries_q   = '0;
    endfunction

    function automatic void push_result(logic [KIND_W-1:0] kind, int byte_v, int off, int len,
                                        logic dir);
        fdc_result_t r;
        r.kind         = kind;
        r.byte_value   = byte_v;
        r.dma_offset   = off;
        r.dma_length   = len;
        r.dma_is_write = dir;
        r.last         = 1'b0;
        caused_results.push_back(r);
    endfunction

    function automatic void finish_request(logic [KIND_W-1:0] kind);
        push_result(kind, 0, 0, 0, 1'b0);
        phase_q = PH_IDLE;
    endfunction

    // Splits the current block into track, head and sector numbers.
    function automatic bit split_block(output int trk, output int hd, output int sec);
        int cyl;
        int rem;
        trk = 0;
        hd  = 0;
        sec = 0;
        if (spt_q == 0 || blk_q >= total_q) begin
            return 1'b0;
        end
        cyl = 2 * int'(spt_q);
        trk = int'(blk_q) / cyl;
        rem = int'(blk_q) % cyl;
        hd  = rem / int'(spt_q);
        sec = rem % int'(spt_q) + 1;
        return 1'b1;
    endfunction

    function automatic void issue_seek();
        int trk;
        int hd;
        int sec;
        if (!split_block(trk, hd, sec)) begin
            finish_request(KIND_INVALID);
            return;
        end
        push_result(KIND_CMD, CMD_SEEK, 0, 0, 1'b0);
        push_result(KIND_CMD, (hd << 2) | int'(unit_q), 0, 0, 1'b0);
        push_result(KIND_CMD, trk, 0, 0, 1'b0);
        phase_q = PH_SEEK;
    endfunction

    function automatic void issue_transfer();
        int trk;
        int hd;
        int sec;
        int n;
        if (!split_block(trk, hd, sec)) begin
            finish_request(KIND_INVALID);
            return;
        end
        // A retry moves a single sector; otherwise run to the end of the cylinder.
        if (retries_q == 0) begin
            n = 2 * int'(spt_q);
            n = n - int'(blk_q) % n;
        end else begin
            n = 1;
        end
        chunk_q = (n < int'(left_q)) ? n : int'(left_q);
        push_result(KIND_DMA, 0, int'(done_q) * 512, int'(chunk_q) * 512, dir_q);
        push_result(KIND_CMD, dir_q ? CMD_WRITE : CMD_READ, 0, 0, 1'b0);
        push_result(KIND_CMD, (hd << 2) | int'(unit_q), 0, 0, 1'b0);
        push_result(KIND_CMD, trk, 0, 0, 1'b0);
        push_result(KIND_CMD, hd, 0, 0, 1'b0);
        push_result(KIND_CMD, sec, 0, 0, 1'b0);
        push_result(KIND_CMD, SIZE_CODE, 0, 0, 1'b0);
        push_result(KIND_CMD, spt_q, 0, 0, 1'b0);
        push_result(KIND_CMD, gap_q, 0, 0, 1'b0);
        push_result(KIND_CMD, DTL_BYTE, 0, 0, 1'b0);
        phase_q = PH_XFER;
    endfunction

    // Works out every result that one accepted input transfer causes.
    function automatic void sequence_event(logic [OP_W-1:0] op, logic unit, logic [BB-1:0] blk,
                                           logic [BB-1:0] cnt, logic wr,
                                           logic [STATUS_W-1:0] st);
        bit          fail;
        int          nb;
        fdc_result_t tail;
        caused_results.delete();
        fail = (st[7:6] != 2'b00);
        case (op)
            OP_START: begin
                if (phase_q != PH_IDLE) begin
                    push_result(KIND_BUSY, 0, 0, 0, 1'b0);
                end else begin
                    unit_q    = unit;
                    blk_q     = blk;
                    left_q    = cnt;
                    dir_q     = wr;
                    done_q    = '0;
                    chunk_q   = '0;
                    retries_q = '0;
                    if (left_q == 0) begin
                        finish_request(KIND_DONE);
                    end else begin
                        issue_seek();
                    end
                end
            end
            OP_SEEK_DONE: begin
                if (phase_q == PH_SEEK) begin
                    if (fail) begin
                        finish_request(KIND_IOERR);
                    end else begin
                        issue_transfer();
                    end
                end
            end
            OP_XFER_DONE: begin
                if (phase_q == PH_XFER) begin
                    if (fail) begin
                        if (retries_q >= retry_lim_q) begin
                            finish_request(KIND_IOERR);
                        end else begin
                            retries_q = retries_q + 1'b1;
                            issue_seek();
                        end
                    end else begin
                        nb        = int'(blk_q) + int'(chunk_q);
                        left_q    = left_q - chunk_q;
                        done_q    = done_q + chunk_q;
                        blk_q     = nb;
                        retries_q = '0;
                        if (left_q == 0) begin
                            finish_request(KIND_DONE);
                        end else if (nb > BLOCK_MASK) begin
                            finish_request(KIND_INVALID);
                        end else begin
                            issue_transfer();
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (caused_results.size() != 0) begin
            tail = caused_results[caused_results.size() - 1];
            tail.last = 1'b1;
            caused_results[caused_results.size() - 1] = tail;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void add_item(logic [OP_W-1:0] op, logic unit, int blk, int cnt, logic wr,
                                     logic [STATUS_W-1:0] st, logic [KIND_W-1:0] kind);
        directed_row_t row;
        row           = '0;
        row.op        = op;
        row.unit      = unit;
        row.blk       = blk;
        row.cnt       = cnt;
        row.wr        = wr;
        row.st        = st;
        row.kind      = kind;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int value);
        directed_row_t row;
        row           = '0;
        row.is_cfg    = 1'b1;
        row.cfg_index = idx;
        row.cfg_value = value;
        directed_rows.push_back(row);
    endfunction

    // Lets the unit run dry: all results in, then time for any ignored transfer.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SPT:   spt_q       = value;
            CFG_TOTAL: total_q     = value;
            CFG_GAP:   gap_q       = value;
            CFG_RETRY: retry_lim_q = value;
            default: begin
            end
        endcase
    endtask

    // Presents one input transfer, waits for it to be taken and records what it
    // should cause. A listed kind replaces the model's results for that row.
    task automatic send_item(logic [OP_W-1:0] op, logic unit, logic [BB-1:0] blk,
                             logic [BB-1:0] cnt, logic wr, logic [STATUS_W-1:0] st,
                             logic [KIND_W-1:0] kind, output int n_res);
        fdc_result_t listed;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_drive_unit   <= unit;
        i_start_block  <= blk;
        i_sector_count <= cnt;
        i_is_write     <= wr;
        i_status_byte  <= st;
        do @(posedge i_clk); while (o_in_stall);
        sequence_event(op, unit, blk, cnt, wr, st);
        if (kind != KIND_PREDICTED) begin
            listed      = '0;
            listed.kind = kind;
            listed.last = 1'b1;
            awaited_results.push_back(listed);
            n_res = 1;
        end else begin
            foreach (caused_results[i]) awaited_results.push_back(caused_results[i]);
            n_res = caused_results.size();
        end
    endtask

    function automatic logic [BB-1:0] pick_block();
        int r;
        int tot;
        r   = $urandom_range(99);
        tot = total_q;
        if (tot == 0 || r < 10) begin
            return $urandom_range(0, BLOCK_MASK);
        end
        // Blocks close to the end of the disk reach the overflow and range checks.
        if (r < 25) begin
            return tot - 1 - $urandom_range(0, (tot > 40) ? 40 : tot - 1);
        end
        return $urandom_range(0, tot - 1);
    endfunction

    function automatic logic [BB-1:0] pick_count();
        int r;
        int cyl;
        r   = $urandom_range(99);
        cyl = 2 * int'(spt_q);
        if (cyl == 0) begin
            cyl = 8;
        end
        if (r < 4) begin
            return 0;
        end else if (r < 12) begin
            return BLOCK_MASK;
        end else if (r < 25) begin
            return $urandom_range(1, BLOCK_MASK);
        end
        return $urandom_range(1, 3 * cyl);
    endfunction

    function automatic logic [STATUS_W-1:0] pick_status(bit fail);
        logic [1:0] top;
        logic [5:0] low;
        top = fail ? $urandom_range(1, 3) : 2'b00;
        low = $urandom_range(0, 63);
        return {top, low};
    endfunction

    // Runs well-formed requests with random content, mixed with random noise.
    // Long requests are cut short by failing them once they have gone on a while.
    task automatic run_phase(int spt, int total, int gap, int retry, int idle_pct,
                             int stall_pct, int target);
        int counted;
        int steps;
        int n_res;
        bit fail;
        write_register(CFG_SPT, spt);
        write_register(CFG_TOTAL, total);
        write_register(CFG_GAP, gap);
        write_register(CFG_RETRY, retry);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        counted = 0;
        steps   = 0;
        while (counted < target) begin
            if (phase_q == PH_IDLE) begin
                steps = 0;
            end
            if ($urandom_range(99) < 12) begin
                send_item($urandom_range(0, 3), $urandom_range(0, 1),
                          $urandom_range(0, BLOCK_MASK), $urandom_range(0, BLOCK_MASK),
                          $urandom_range(0, 1), $urandom_range(0, 255), KIND_PREDICTED, n_res);
            end else if (phase_q == PH_IDLE) begin
                send_item(OP_START, $urandom_range(0, 1), pick_block(), pick_count(),
                          $urandom_range(0, 1), $urandom_range(0, 255), KIND_PREDICTED, n_res);
            end else begin
                fail = (steps > 10) ||
                       ($urandom_range(99) < ((phase_q == PH_SEEK) ? 8 : 20));
                send_item((phase_q == PH_SEEK) ? OP_SEEK_DONE : OP_XFER_DONE,
                          $urandom_range(0, 1), $urandom_range(0, BLOCK_MASK),
                          $urandom_range(0, BLOCK_MASK), $urandom_range(0, 1),
                          pick_status(fail), KIND_PREDICTED, n_res);
            end
            steps++;
            if (n_res != 0) begin
                counted++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = {o_kind, o_byte_value, o_dma_offset, o_dma_length, o_dma_is_write, o_last};
            if (awaited_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result: expected none, got kind %0d byte %h ",
                             $time, seen.kind, seen.byte_value,
                             "offset %0d length %0d write %0b last %0b",
                             seen.dma_offset, seen.dma_length, seen.dma_is_write, seen.last);
                end
            end else begin
                want = awaited_results.pop_front();
                if (seen !== want) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: expected kind %0d byte %h offset %0d length %0d ",
                                 $time, want.kind, want.byte_value, want.dma_offset,
                                 want.dma_length, "write %0b last %0b, ",
                                 want.dma_is_write, want.last,
                                 "got kind %0d byte %h offset %0d length %0d write %0b last %0b",
                                 seen.kind, seen.byte_value, seen.dma_offset, seen.dma_length,
                                 seen.dma_is_write, seen.last);
                    end
                end
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("floppy_transfer_sequencer_unit: mismatch");
        $finish;
    end

    initial begin
        int n_res;
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ignored transfers while idle, then the ending and refusing cases.
        add_item(OP_XFER_DONE, 1'b0, 0, 0, 1'b0, 8'h00, KIND_PREDICTED);
        add_item(OP_SEEK_DONE, 1'b1, BLOCK_MASK, BLOCK_MASK, 1'b1, 8'hFF, KIND_PREDICTED);
        add_item(OP_RESERVED, 1'b0, 0, 1, 1'b0, 8'h00, KIND_PREDICTED);
        add_item(OP_START, 1'b0, 5, 0, 1'b0, 8'h00, KIND_DONE);
        add_item(OP_START, 1'b0, RST_TOTAL, 5, 1'b0, 8'h00, KIND_INVALID);
        add_item(OP_START, 1'b1, BLOCK_MASK, BLOCK_MASK, 1'b1, 8'hFF, KIND_INVALID);
        // One-sector read, with a busy start and wrong-phase completions in between.
        add_item(OP_START, 1'b1, 0, 1, 1'b0, 8'h00, KIND_PREDICTED);
        add_item(OP_START, 1'b0, 100, 4, 1'b1, 8'h00, KIND_BUSY);
        add_item(OP_XFER_DONE, 1'b0, 0, 0, 1'b0, 8'h00, KIND_PREDICTED);
        add_item(OP_SEEK_DONE, 1'b0, 0, 0, 1'b0, 8'h3F, KIND_PREDICTED);
        add_item(OP_SEEK_DONE, 1'b0, 0, 0, 1'b0, 8'h00, KIND_PREDICTED);
        add_item(OP_XFER_DONE, 1'b0, 0, 0, 1'b0, 8'h00, KIND_DONE);
        // A failed seek ends the request.
        add_item(OP_START, 1'b0, RST_TOTAL - 1, BLOCK_MASK, 1'b1, 8'h00, KIND_PREDICTED);
        add_item(OP_SEEK_DONE, 1'b0, 0, 0, 1'b0, 8'hC0, KIND_IOERR);
        // Two retries, then the retry limit is lowered below the count reached.
        add_item(OP_START, 1'b1, 35, 40, 1'b1, 8'h00, KIND_PREDICTED);
        add_item(OP_SEEK_DONE, 1'b0, 0, 0, 1'b0, 8'h20, KIND_PREDICTED);
        add_item(OP_XFER_DONE, 1'b0, 0, 0, 1'b0, 8'h40, KIND_PREDICTED);
        add_item(OP_SEEK_DONE, 1'b0, 0, 0, 1'b0, 8'h00, KIND_PREDICTED);
        add_item(OP_XFER_DONE, 1'b0, 0, 0, 1'b0, 8'hFF, KIND_PREDICTED);
        add_item(OP_SEEK_DONE, 1'b0, 0, 0, 1'b0, 8'h00, KIND_PREDICTED);
        add_cfg(CFG_RETRY, 1);
        add_item(OP_XFER_DONE, 1'b0, 0, 0, 1'b0, 8'h80, KIND_IOERR);
        // With no sectors per track every block is out of range.
        add_cfg(CFG_SPT, 0);
        add_item(OP_START, 1'b0, 0, 3, 1'b0, 8'h00, KIND_INVALID);
        // One sector per track: track number above 255, then the block overflows.
        add_cfg(CFG_SPT, 1);
        add_cfg(CFG_TOTAL, BLOCK_MASK);
        add_cfg(CFG_RETRY, 8);
        add_item(OP_START, 1'b1, BLOCK_MASK - 1, BLOCK_MASK, 1'b0, 8'h00, KIND_PREDICTED);
        add_item(OP_SEEK_DONE, 1'b0, 0, 0, 1'b0, 8'h00, KIND_PREDICTED);
        add_item(OP_XFER_DONE, 1'b0, 0, 0, 1'b0, 8'h00, KIND_INVALID);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_register(directed_rows[i].cfg_index, directed_rows[i].cfg_value);
            end else begin
                send_item(directed_rows[i].op, directed_rows[i].unit, directed_rows[i].blk,
                          directed_rows[i].cnt, directed_rows[i].wr, directed_rows[i].st,
                          directed_rows[i].kind, n_res);
            end
        end

        run_phase(RST_SPT, RST_TOTAL, RST_GAP, RST_RETRY, 0, 0, 45);
        run_phase(63, BLOCK_MASK, 255, 15, 75, 0, 45);
        run_phase(1, BLOCK_MASK, 0, 0, 0, 75, 45);
        run_phase(37, 1500, 170, 2, 13, 13, 45);
        run_phase(9, 0, 91, 1, 13, 13, 10);
        run_phase(5, 700, 200, 4, 0, 0, 45);

        wait_quiet();
        if (error_count == 0) begin
            $display("floppy_transfer_sequencer_unit: match");
        end else begin
            $display("floppy_transfer_sequencer_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/ftsq_pkg.sv
design/ftsq_divider.sv
design/floppy_transfer_sequencer_unit.sv
tb/tb.sv
